FILE: hw/rtl/olist_pkg.sv
// Shared types and constants for the ordered list block.
// Used by olist_cell, olist_scan and ordered_list_insert_erase_find.
`default_nettype none

package olist_pkg;

  localparam int DepthDefault     = 64;
  localparam int DataWidthDefault = 32;
  localparam int ScanLane         = 8;

  typedef enum logic [2:0] {
    MODE_INSERT     = 3'd0,
    MODE_ERASE      = 3'd1,
    MODE_FIND       = 3'd2,
    MODE_PUSH_BACK  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_PUSH_FRONT = 3'd5,
    MODE_POP_FRONT  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/olist_cell.sv
// One list entry: holds a value, loads it or takes a neighbor's, compares to a key.
// Depends on olist_pkg.
`default_nettype none

module olist_cell
  import olist_pkg::*;
#(
  parameter int DataWidth = DataWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire cell_op_e             op_i,
  input  wire logic [DataWidth-1:0] value_i,
  input  wire logic [DataWidth-1:0] lower_i,
  input  wire logic [DataWidth-1:0] upper_i,
  input  wire logic [DataWidth-1:0] key_i,
  output logic      [DataWidth-1:0] data_o,
  output logic                      match_o
);

  logic [DataWidth-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_LOAD:       data_d = value_i;
      CELL_FROM_LOWER: data_d = lower_i;
      CELL_FROM_UPPER: data_d = upper_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

`default_nettype wire

FILE: hw/rtl/olist_scan.sv
// First-match search over the cells' match vector, eight entries per cycle.
// Depends on olist_pkg.
`default_nettype none

module olist_scan
  import olist_pkg::*;
#(
  parameter int Depth = DepthDefault,
  parameter int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic [Depth-1:0] match_i,
  output scan_stat_t            stat_o,
  output logic      [IdxW-1:0]  index_o
);

  localparam int NumChunks = (Depth + ScanLane - 1) / ScanLane;
  localparam int PadW      = NumChunks * ScanLane;
  localparam int ChW       = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int BaseW     = $clog2(PadW);
  localparam int LowW      = (ScanLane > 1) ? $clog2(ScanLane) : 1;

  logic                active_q, active_d;
  logic [PadW-1:0]     vec_q, vec_d;
  logic [BaseW-1:0]    base_q, base_d;
  logic [ChW-1:0]      left_q, left_d;
  logic [ScanLane-1:0] chunk;
  logic [LowW-1:0]     low;
  logic                any_hit, last;

  assign chunk   = vec_q[ScanLane-1:0];
  assign any_hit = |chunk;
  assign last    = (left_q == '0);

  always_comb begin
    low = '0;
    for (int i = ScanLane - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        low = LowW'(i);
      end
    end
  end

  assign stat_o.busy = active_q;
  assign stat_o.done = active_q && (any_hit || last);
  assign stat_o.hit  = active_q && any_hit;
  assign index_o     = IdxW'(base_q + BaseW'(low));

  always_comb begin
    active_d = active_q;
    vec_d    = vec_q;
    base_d   = base_q;
    left_d   = left_q;
    if (load_i) begin
      active_d = 1'b1;
      vec_d    = PadW'(match_i);
      base_d   = '0;
      left_d   = ChW'(NumChunks - 1);
    end else if (active_q) begin
      if (any_hit || last) begin
        active_d = 1'b0;
      end else begin
        vec_d  = vec_q >> ScanLane;
        base_d = base_q + BaseW'(ScanLane);
        left_d = left_q - ChW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    base_q <= base_d;
    left_q <= left_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_list_insert_erase_find.sv
// Top level of the ordered list: a row of entry cells, the count and the find scan.
// Depends on olist_pkg, olist_cell and olist_scan.
//
//  channel   ports                                  handshake
//  request   mode_i, position_i, value_i            start_i && !busy_o
//  result    status_o, found_index_o, count_o       valid_o, one cycle
//
// Insert, erase, push and pop act on the accepted request; the result strobes the next cycle
// and a new request may follow at once. Find loads the scan, which walks the eight-entry
// chunks (1 .. ceil(DEPTH/8) of them) up to the first hit or the last, busy_o high meanwhile.
// Reset clears the count and the scan; entries hold no reset.
// Results cannot be stalled by the receiver.
`default_nettype none

module ordered_list_insert_erase_find
  import olist_pkg::*;
#(
  parameter int DEPTH      = DepthDefault,
  parameter int DATA_WIDTH = DataWidthDefault,
  parameter int CntW       = $clog2(DEPTH + 1),
  parameter int IdxW       = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [2:0]            mode_i,
  input  wire logic [CntW-1:0]       position_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  output logic                       valid_o,
  output logic [1:0]                 status_o,
  output logic [IdxW-1:0]            found_index_o,
  output logic [CntW-1:0]            count_o
);

  logic            acc;
  mode_e           mode;
  logic            full, empty;
  logic            shift_up, shift_down;
  logic [CntW-1:0] at;
  status_e         status;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            find_load;

  logic                  valid_q, valid_d;
  status_e               status_q, status_d;
  logic [IdxW-1:0]       found_q, found_d;
  logic [CntW-1:0]       rcnt_q, rcnt_d;

  logic [DATA_WIDTH-1:0] data   [DEPTH];
  cell_op_e              cell_op[DEPTH];
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      match_live;
  scan_stat_t            scan;
  logic [IdxW-1:0]       scan_index;

  assign busy_o = scan.busy;
  assign acc    = start_i && !busy_o;
  assign mode   = mode_e'(mode_i);
  assign full   = (cnt_q == CntW'(DEPTH));
  assign empty  = (cnt_q == '0);

  always_comb begin
    shift_up   = 1'b0;
    shift_down = 1'b0;
    at         = '0;
    status     = ST_OK;
    cnt_d      = cnt_q;
    find_load  = 1'b0;
    if (acc) begin
      case (mode)
        MODE_INSERT: begin
          if (position_i > cnt_q) begin
            status = ST_BAD;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            shift_up = 1'b1;
            at       = position_i;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        MODE_ERASE: begin
          if (position_i >= cnt_q) begin
            status = ST_BAD;
          end else begin
            shift_down = 1'b1;
            at         = position_i;
            cnt_d      = cnt_q - CntW'(1);
          end
        end
        MODE_FIND: begin
          find_load = 1'b1;
        end
        MODE_PUSH_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            shift_up = 1'b1;
            at       = cnt_q;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            status = ST_BAD;
          end else begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
        MODE_PUSH_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            shift_up = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            status = ST_BAD;
          end else begin
            shift_down = 1'b1;
            cnt_d      = cnt_q - CntW'(1);
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;

    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = data[k+1];
    end

    always_comb begin
      cell_op[k] = CELL_HOLD;
      if (shift_up && (CntW'(k) == at)) begin
        cell_op[k] = CELL_LOAD;
      end else if (shift_up && (CntW'(k) > at)) begin
        cell_op[k] = CELL_FROM_LOWER;
      end else if (shift_down && (CntW'(k) >= at)) begin
        cell_op[k] = CELL_FROM_UPPER;
      end
    end

    assign match_live[k] = match[k] && (CntW'(k) < cnt_q);

    olist_cell #(
      .DataWidth(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[k]),
      .value_i(value_i),
      .lower_i(lower),
      .upper_i(upper),
      .key_i  (value_i),
      .data_o (data[k]),
      .match_o(match[k])
    );
  end

  olist_scan #(
    .Depth(DEPTH),
    .IdxW (IdxW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (find_load),
    .match_i(match_live),
    .stat_o (scan),
    .index_o(scan_index)
  );

  always_comb begin
    valid_d  = 1'b0;
    status_d = status_q;
    found_d  = found_q;
    rcnt_d   = rcnt_q;
    if (scan.done) begin
      valid_d  = 1'b1;
      status_d = scan.hit ? ST_OK : ST_NOTFOUND;
      found_d  = scan.hit ? scan_index : '0;
      rcnt_d   = cnt_q;
    end else if (acc && !find_load) begin
      valid_d  = 1'b1;
      status_d = status;
      found_d  = '0;
      rcnt_d   = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    rcnt_q   <= rcnt_d;
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign count_o       = rcnt_q;

`ifndef ASSERT_OFF
  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode_i == MODE_FIND)) |=> busy_o)
    else $error("find request did not raise busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_FULL)) |-> (count_o == CntW'(DEPTH)))
    else $error("full status with count below capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(acc) && $past(!find_load)))
    else $error("count changed without a request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("count beyond capacity");
`endif

endmodule

`default_nettype wire
